// ----- hdl/gba_pkg.sv -----
// Shared types and constants for the hash group-by aggregator.
// No dependencies; imported by the aggregator, the hash unit and the checker.
package gba_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int SLOT_W            = 6;
    localparam int KEY_W             = 32;
    localparam int VAL_W             = 32;
    localparam int SUM_W             = 64;
    localparam int EN_W              = 4;

    localparam logic [EN_W-1:0] ENABLE_RESET = 4'hF;

    // aggregate_enable bit positions
    localparam int EN_COUNT = 0;
    localparam int EN_SUM   = 1;
    localparam int EN_MIN   = 2;
    localparam int EN_MAX   = 3;

    // item function codes
    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // result status codes
    localparam logic ST_ENTRY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    // one table slot as held in memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] min;
        logic [VAL_W-1:0] max;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HASH   = 6'b000010,
        S_PROBE  = 6'b000100,
        S_FULL   = 6'b001000,
        S_FL_RD  = 6'b010000,
        S_FL_OUT = 6'b100000
    } t_state;

endpackage

// ----- hdl/hash_group_by_aggregator.sv -----
// Hash group-by aggregator: accumulate keyed items into a linear-probed table, flush on demand.
// Accumulate: accept, 2 hash stages, then probe slot by slot until an empty slot or a key hit;
// a full table posts the error result once every slot has been probed.
// Flush: each slot is read, then its result is posted, one result per slot; output stalls hold it.
// Synchronous active-low reset empties the table and sets aggregate_enable to all ones.
// Memory contents are not cleared; per-slot valid flops mark which entries hold a group.
module hash_group_by_aggregator
    import gba_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [EN_W-1:0]   i_cfg_data,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_elem_key,
    input  logic [VAL_W-1:0]  i_sum_value,
    input  logic [VAL_W-1:0]  i_min_value,
    input  logic [VAL_W-1:0]  i_max_value,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic              o_occupied,
    output logic [KEY_W-1:0]  o_entry_key,
    output logic [VAL_W-1:0]  o_entry_count,
    output logic [SUM_W-1:0]  o_entry_sum,
    output logic [VAL_W-1:0]  o_entry_min,
    output logic [VAL_W-1:0]  o_entry_max,
    output logic              o_last
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // control state
    t_state             r_state, n_state;
    logic [EN_W-1:0]    r_enable;
    logic [TABLE_ENTRIES-1:0] r_slot_valid;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_probes;
    logic               r_out_valid;

    // held item payload
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_sv, r_mnv, r_mxv;

    // output payload
    logic               r_status, r_occupied, r_last;
    logic [SLOT_W-1:0]  r_slot_index;
    t_entry             r_out;

    // hash unit
    logic               hash_start, hash_done;
    logic [IDX_W-1:0]   hash_idx;

    // table memory
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    t_entry             ram_rdata, ram_wdata;

    logic               accept, out_free, out_load, slot_full, key_hit;
    logic [IDX_W-1:0]   idx_next;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = out_free && ((r_state == S_FULL) || (r_state == S_FL_OUT));
    assign idx_next = (r_idx == LAST_IDX) ? '0 : IDX_W'(r_idx + 1'b1);

    // the probe sees the entry read in the previous cycle at r_idx
    assign slot_full = r_slot_valid[r_idx];
    assign key_hit   = slot_full && (ram_rdata.key == r_key);

    assign hash_start = accept && (i_func == FUNC_ACCUM);

    gba_hash #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_elem_key),
        .o_done  (hash_done),
        .o_idx   (hash_idx)
    );

    gba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Build the write-back entry: create on an empty slot, fold in on a hit.
    always_comb begin
        if (!slot_full) begin
            ram_wdata.key   = r_key;
            ram_wdata.count = VAL_W'(1);
            ram_wdata.sum   = SUM_W'(r_sv);
            ram_wdata.min   = r_mnv;
            ram_wdata.max   = r_mxv;
        end else begin
            ram_wdata.key   = ram_rdata.key;
            ram_wdata.count = VAL_W'(ram_rdata.count + 1'b1);
            ram_wdata.sum   = SUM_W'(ram_rdata.sum + SUM_W'(r_sv));
            ram_wdata.min   = (r_mnv < ram_rdata.min) ? r_mnv : ram_rdata.min;
            ram_wdata.max   = (r_mxv > ram_rdata.max) ? r_mxv : ram_rdata.max;
        end
    end

    // Sequencer: read address, write strobe and next state.
    // Only one item is in flight and its write-back ends it, so a read never
    // overlaps a pending write to the same slot; no forwarding is needed.
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_func == FUNC_FLUSH) ? S_FL_RD : S_HASH;
                end
            end
            S_HASH: begin
                ram_raddr = hash_idx;
                if (hash_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                ram_raddr = idx_next;
                if (!slot_full || key_hit) begin
                    ram_we  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_probes == LAST_IDX) begin
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FL_RD: begin
                n_state = S_FL_OUT;
            end
            S_FL_OUT: begin
                // hold the read address so the slot data stays put while stalled
                if (out_free) begin
                    n_state = (r_idx == LAST_IDX) ? S_IDLE : S_FL_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_enable     <= ENABLE_RESET;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_probes     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_enable <= i_cfg_data;
            end

            // drop the result once the consumer takes it, unless a new one replaces it
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= '0;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_idx    <= hash_idx;
                        r_probes <= '0;
                    end
                end
                S_PROBE: begin
                    if (!slot_full || key_hit) begin
                        r_slot_valid[r_idx] <= 1'b1;
                    end else begin
                        // advance to the next slot, wrapping at the end
                        r_idx    <= idx_next;
                        r_probes <= IDX_W'(r_probes + 1'b1);
                    end
                end
                S_FULL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                S_FL_RD: begin
                end
                S_FL_OUT: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_slot_valid[r_idx] <= 1'b0;
                        r_idx               <= idx_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Item payload and result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_elem_key;
            r_sv  <= i_sum_value;
            r_mnv <= i_min_value;
            r_mxv <= i_max_value;
        end
        if ((r_state == S_FULL) && out_free) begin
            r_status     <= ST_FULL;
            r_slot_index <= '0;
            r_occupied   <= 1'b0;
            r_out        <= '0;
            r_last       <= 1'b1;
        end else if ((r_state == S_FL_OUT) && out_free) begin
            r_status     <= ST_ENTRY;
            r_slot_index <= SLOT_W'(r_idx);
            r_occupied   <= slot_full;
            r_last       <= (r_idx == LAST_IDX);
            // empty slots and disabled aggregates read as zero
            r_out.key    <= slot_full ? ram_rdata.key : '0;
            r_out.count  <= (slot_full && r_enable[EN_COUNT]) ? ram_rdata.count : '0;
            r_out.sum    <= (slot_full && r_enable[EN_SUM])   ? ram_rdata.sum   : '0;
            r_out.min    <= (slot_full && r_enable[EN_MIN])   ? ram_rdata.min   : '0;
            r_out.max    <= (slot_full && r_enable[EN_MAX])   ? ram_rdata.max   : '0;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot_index;
    assign o_occupied    = r_occupied;
    assign o_entry_key   = r_out.key;
    assign o_entry_count = r_out.count;
    assign o_entry_sum   = r_out.sum;
    assign o_entry_min   = r_out.min;
    assign o_entry_max   = r_out.max;
    assign o_last        = r_last;

endmodule

// ----- hdl/gba_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the slot table.
module gba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/gba_hash.sv -----
// Home-slot hash: key modulo TABLE_ENTRIES in two register stages.
// Folds the key bytes by their weights mod N, then reduces by reciprocal multiply.
module gba_hash
    import gba_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_done,
    output logic [IDX_W-1:0] o_idx
);

    // byte weights 2^(8i) mod N; folded value stays below 2^16
    localparam logic [15:0] W1 = 16'((1 << 8) % TABLE_ENTRIES);
    localparam logic [15:0] W2 = 16'((1 << 16) % TABLE_ENTRIES);
    localparam logic [15:0] W3 = 16'((1 << 24) % TABLE_ENTRIES);
    // ceil(2^22 / N): exact quotient for any 16-bit dividend
    localparam int          RSH = 22;
    localparam logic [RSH-1:0] RECIP =
        RSH'(((1 << RSH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES);
    localparam logic [15:0] NV = 16'(TABLE_ENTRIES);

    logic        r_v1, r_v2;
    logic [15:0] r_x, r_x2, r_q;
    logic [15:0] n_x;
    logic [RSH+15:0] prod;

    assign n_x = 16'(i_key[7:0])
               + 16'(16'(i_key[15:8])  * W1)
               + 16'(16'(i_key[23:16]) * W2)
               + 16'(16'(i_key[31:24]) * W3);

    assign prod = (RSH+16)'(r_x) * (RSH+16)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        r_x  <= n_x;
        r_x2 <= r_x;
        r_q  <= prod[RSH+15:RSH];
    end

    assign o_done = r_v2;
    assign o_idx  = IDX_W'(16'(r_x2 - 16'(r_q * NV)));

endmodule

// ----- hdl/gba_checker.sv -----
// Port-level assertions for the hash group-by aggregator, bound to the top level.
// Depends on gba_pkg and hash_group_by_aggregator.
module gba_checker
    import gba_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_status,
    input logic [SLOT_W-1:0] o_slot_index,
    input logic              o_occupied,
    input logic [KEY_W-1:0]  o_entry_key,
    input logic [VAL_W-1:0]  o_entry_count,
    input logic [SUM_W-1:0]  o_entry_sum,
    input logic [VAL_W-1:0]  o_entry_min,
    input logic [VAL_W-1:0]  o_entry_max,
    input logic              o_last
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

    // table-full error is a single, final, empty result
    a_full_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |->
            (o_last && !o_occupied && o_entry_key == '0 && o_entry_sum == '0))
        else $error("table full result malformed");

    // an empty slot reports all-zero contents
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ENTRY && !o_occupied) |->
            (o_entry_key == '0 && o_entry_count == '0 && o_entry_sum == '0 &&
             o_entry_min == '0 && o_entry_max == '0))
        else $error("empty slot with nonzero contents");

    // the flush run ends on the top slot, and only there
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ENTRY) |-> (o_last == (o_slot_index == LAST_SLOT)))
        else $error("flush last flag on wrong slot");

    // block stays busy while a flush run still has results to post
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ENTRY && !o_last) |-> o_in_stall)
        else $error("input open in the middle of a flush");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_slot_index) && $stable(o_status) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind hash_group_by_aggregator gba_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_gba_checker (.*);
